[hw/rtl/assert_macros.svh]
// Assertion helpers, sampled on clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[hw/rtl/epsc_pkg.sv]
package epsc_pkg;

  localparam int CAP_IN_W     = 24;
  localparam int DIR_W        = 2;
  localparam int CLOCK_W      = 27;
  localparam int SPEED_W      = 28;
  localparam int COUNT_W      = 32;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 64;
  localparam int DIV_STEPS    = CLOCK_W;
  localparam int STEP_CNT_W   = $clog2(DIV_STEPS);
  localparam int CAPTURE_BITS_DEF = 24;

  localparam logic [CLOCK_W-1:0] CLOCK_RATE_RST = CLOCK_W'(80000000);

  localparam logic [DIR_W-1:0] DIR_FWD   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_REV   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_STOP  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd3;

  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

[hw/rtl/epsc_ctrl.sv]
module epsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_mode,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  epsc_pkg::dp_sts_t  sts,
  output epsc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_mode == epsc_pkg::MODE_CLEAR) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/epsc_dp.sv]
module epsc_dp #(
  parameter int CAPTURE_BITS = epsc_pkg::CAPTURE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wen,
  input  logic [epsc_pkg::CLOCK_W-1:0]         cfg_wdata,
  input  logic                                 in_mode,
  input  logic [epsc_pkg::CAP_IN_W-1:0]        in_capture,
  input  logic [epsc_pkg::DIR_W-1:0]           in_dir,
  input  epsc_pkg::dp_cmd_t                    cmd,
  output epsc_pkg::dp_sts_t                    sts,
  output logic [epsc_pkg::COUNT_W-1:0]         tick_count,
  output logic [epsc_pkg::SPEED_W-1:0]         speed
);

  localparam int CB = CAPTURE_BITS;

  logic [epsc_pkg::CLOCK_W-1:0]    clock_rate_r;
  logic [CB-1:0]                   last_cap_r;
  logic [epsc_pkg::COUNT_W-1:0]    tick_r;
  logic [epsc_pkg::SPEED_W-1:0]    speed_r;

  logic                            mode_r;
  logic [epsc_pkg::DIR_W-1:0]      dir_r;
  logic [CB-1:0]                   cap_r;
  logic [CB-1:0]                   div_r;
  logic [CB-1:0]                   rem_r, rem_nxt;
  logic [epsc_pkg::CLOCK_W-1:0]    quo_r, quo_nxt;
  logic [epsc_pkg::STEP_CNT_W-1:0] cnt_r;

  logic [CB+epsc_pkg::CAP_IN_W-1:0] cap_wide;
  logic [CB-1:0]                   cap_w;
  logic [CB-1:0]                   period_raw;
  logic [CB-1:0]                   period_w;
  logic [CB:0]                     rem_sh;
  logic                            fits;
  logic [epsc_pkg::SPEED_W-1:0]    mag;

  assign cap_wide   = {{CB{1'b0}}, in_capture};
  assign cap_w      = cap_wide[CB-1:0];
  assign period_raw = last_cap_r - cap_w;
  assign period_w   = (period_raw == '0) ? CB'(1) : period_raw;

  assign rem_sh  = {rem_r, quo_r[epsc_pkg::CLOCK_W-1]};
  assign fits    = (rem_sh >= {1'b0, div_r});
  assign rem_nxt = fits ? CB'(rem_sh - {1'b0, div_r}) : rem_sh[CB-1:0];
  assign quo_nxt = {quo_r[epsc_pkg::CLOCK_W-2:0], fits};

  assign sts.div_last = (cnt_r == epsc_pkg::STEP_CNT_W'(epsc_pkg::DIV_STEPS - 1));

  assign mag        = {1'b0, quo_r};
  assign tick_count = tick_r;
  assign speed      = speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= epsc_pkg::CLOCK_RATE_RST;
      last_cap_r   <= '0;
      tick_r       <= '0;
      speed_r      <= '0;
    end else begin
      if (cfg_wen) begin
        clock_rate_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        if (mode_r == epsc_pkg::MODE_CLEAR) begin
          tick_r <= '0;
        end else begin
          last_cap_r <= cap_r;
          unique case (dir_r)
            epsc_pkg::DIR_FWD: begin
              speed_r <= mag;
              tick_r  <= tick_r + 1'b1;
            end
            epsc_pkg::DIR_REV: begin
              speed_r <= '0 - mag;
              tick_r  <= tick_r - 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      dir_r  <= in_dir;
      cap_r  <= cap_w;
      div_r  <= period_w;
      rem_r  <= '0;
      quo_r  <= clock_rate_r;
      cnt_r  <= '0;
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

[hw/rtl/encoder_period_speed_counter.sv]
// Edge item: loaded on the input transfer, through the 27-step restoring divider
// (ST_DIV), committed from ST_FIN once the output is free; a count clear skips
// ST_DIV. A new item is taken while the previous result waits on the output.
// Reset (rst_n, synchronous, active low): count, speed and last capture clear,
// clock_rate returns to 80000000, no result pending.
`include "assert_macros.svh"

module encoder_period_speed_counter #(
  parameter int CAPTURE_BITS = epsc_pkg::CAPTURE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wen,
  input  logic [epsc_pkg::CLOCK_W-1:0]         cfg_wdata,    // clock_rate
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [epsc_pkg::IN_DATA_W-1:0]       in_tdata,     // capture_value, direction
  input  logic                                 in_tuser,     // mode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [epsc_pkg::OUT_DATA_W-1:0]      out_tdata     // tick_count, speed
);

  epsc_pkg::dp_cmd_t               cmd;
  epsc_pkg::dp_sts_t               sts;
  logic [epsc_pkg::COUNT_W-1:0]    tick_count;
  logic [epsc_pkg::SPEED_W-1:0]    speed;

  epsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  epsc_dp #(
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser),
    .in_capture (in_tdata[epsc_pkg::CAP_IN_W-1:0]),
    .in_dir     (in_tdata[epsc_pkg::CAP_IN_W +: epsc_pkg::DIR_W]),
    .cmd        (cmd),
    .sts        (sts),
    .tick_count (tick_count),
    .speed      (speed)
  );

  assign out_tdata = {{(epsc_pkg::OUT_DATA_W - epsc_pkg::COUNT_W - epsc_pkg::SPEED_W){1'b0}},
                      speed, tick_count};

  `CHK_NEXT(a_busy_after_transfer, in_tvalid && in_tready, !in_tready)
  `CHK_IMPL(a_commit_needs_slot, cmd.commit, !out_tvalid || out_tready)
  `CHK_NEXT(a_commit_shows_result, cmd.commit, out_tvalid)
  `CHK_IMPL(a_no_load_while_div, cmd.step, !cmd.load && !cmd.commit)

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import epsc_pkg::*;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [SPEED_W-1:0] speed;
  } reading_t;

  class tacho_board;
    logic [CLOCK_W-1:0]  rate;
    logic [CAP_IN_W-1:0] last_cap;
    logic [COUNT_W-1:0]  ticks;
    logic [SPEED_W-1:0]  speed;
    reading_t            readings[$];
    int                  errors;

    function new();
      rate = CLOCK_RATE_RST;
      last_cap = '0;
      ticks = '0;
      speed = '0;
      errors = 0;
    endfunction

    function void set_rate(logic [CLOCK_W-1:0] value);
      rate = value;
    endfunction

    function int pending();
      return readings.size();
    endfunction

    function void accept_item(logic mode, logic [CAP_IN_W-1:0] cap, logic [DIR_W-1:0] dir);
      logic [CAP_IN_W-1:0] period;
      logic [SPEED_W-1:0]  mag;
      reading_t            r;
      if (mode == MODE_CLEAR) begin
        ticks = '0;
      end else begin
        period = last_cap - cap;
        if (period == '0) period = 1;
        mag = SPEED_W'(rate / period);
        if (dir == DIR_FWD) begin
          speed = mag;
          ticks = ticks + 1;
        end else if (dir == DIR_REV) begin
          speed = -mag;
          ticks = ticks - 1;
        end
        last_cap = cap;
      end
      r.count = ticks;
      r.speed = speed;
      readings.push_back(r);
    endfunction

    function void report(string field, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_output(logic [OUT_DATA_W-1:0] data);
      reading_t            r;
      logic [COUNT_W-1:0]  count;
      logic [SPEED_W-1:0]  spd;
      count = data[COUNT_W-1:0];
      spd = data[COUNT_W +: SPEED_W];
      if (readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, got count %0d speed %0d", $time,
                 $signed(count), $signed(spd));
        return;
      end
      r = readings.pop_front();
      if (count !== r.count) report("tick_count", $signed(r.count), $signed(count));
      if (spd !== r.speed) report("speed", $signed(r.speed), $signed(spd));
    endfunction

    function void finish();
      if (readings.size() != 0) begin
        errors += readings.size();
        $display("%0t: %0d expected transfers never arrived", $time, readings.size());
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [CLOCK_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  tacho_board sb = new();
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  sent = 0;
  int  received = 0;
  int  rate_writes = 0;

  encoder_period_speed_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("timeout at %0t", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int rand_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // result side
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = rand_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_output(out_tdata);
      received++;
    end
  end

  task automatic send_item(input logic mode, input logic [CAP_IN_W-1:0] cap,
                           input logic [DIR_W-1:0] dir);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {{(IN_DATA_W - CAP_IN_W - DIR_W){1'b0}}, dir, cap};
    do @(posedge clk); while (!in_tready);
    sb.accept_item(mode, cap, dir);
    sent++;
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_rate(input logic [CLOCK_W-1:0] value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    sb.set_rate(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
    rate_writes++;
  endtask

  task automatic send_random();
    int unsigned         r;
    logic                mode;
    logic [CAP_IN_W-1:0] cap;
    logic [DIR_W-1:0]    dir;
    r = $urandom_range(99);
    mode = (r < 8) ? MODE_CLEAR : MODE_EDGE;
    r = $urandom_range(99);
    if (r < 10) begin
      cap = CAP_IN_W'($urandom);
    end else if (r < 20) begin
      cap = sb.last_cap;
    end else begin
      case ($urandom_range(3))
        0: cap = sb.last_cap - CAP_IN_W'($urandom_range(16, 1));
        1: cap = sb.last_cap - CAP_IN_W'($urandom_range(4095, 1));
        2: cap = sb.last_cap - CAP_IN_W'($urandom_range(24'hFFFFF, 1));
        default: cap = sb.last_cap - CAP_IN_W'($urandom_range(24'hFFFFFF, 1));
      endcase
    end
    r = $urandom_range(99);
    if (r < 40) dir = DIR_FWD;
    else if (r < 70) dir = DIR_REV;
    else if (r < 85) dir = DIR_STOP;
    else dir = DIR_BRAKE;
    send_item(mode, cap, dir);
  endtask

  task automatic run_phase(input int count);
    repeat (count) send_random();
  endtask

  initial begin
    int waited;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset clock rate, first edge measured from zero
    send_item(MODE_EDGE, 24'h000000, DIR_FWD);
    send_item(MODE_EDGE, 24'hFFFFFF, DIR_REV);
    send_item(MODE_EDGE, 24'h000000, DIR_FWD);
    send_item(MODE_EDGE, 24'h000000, DIR_STOP);
    send_item(MODE_EDGE, 24'h000064, DIR_BRAKE);
    send_item(MODE_EDGE, 24'h0000C8, DIR_FWD);
    send_item(MODE_CLEAR, CAP_IN_W'($urandom), DIR_W'($urandom));
    send_item(MODE_EDGE, 24'h000032, DIR_REV);
    send_item(MODE_CLEAR, 24'hFFFFFF, DIR_BRAKE);
    drain(32);

    write_rate(27'h7FFFFFF);
    send_item(MODE_EDGE, 24'h000031, DIR_FWD);
    send_item(MODE_EDGE, 24'h000031, DIR_REV);
    send_item(MODE_EDGE, 24'h800031, DIR_FWD);
    send_item(MODE_EDGE, 24'hAAAAAA, DIR_REV);
    send_item(MODE_EDGE, 24'h555555, DIR_FWD);
    drain(32);

    write_rate(27'd1);
    send_item(MODE_EDGE, 24'h555554, DIR_FWD);
    send_item(MODE_EDGE, 24'h555552, DIR_REV);
    send_item(MODE_EDGE, 24'h555552, DIR_FWD);
    send_item(MODE_CLEAR, 24'h000000, DIR_FWD);
    drain(32);

    write_rate(CLOCK_RATE_RST);
    run_phase(80);
    drain(32);

    write_rate(27'h7FFFFFF);
    steady = 1'b1;
    run_phase(80);
    steady = 1'b0;
    drain(32);

    // receiver blocked while sender keeps offering, then a full pause
    write_rate(27'd1);
    hold_req = 1'b1;
    run_phase(40);
    drain(0);
    run_phase(40);
    drain(32);

    write_rate(CLOCK_W'($urandom_range(27'h7FFFFFF, 1)));
    run_phase(80);
    drain(32);

    write_rate(CLOCK_W'($urandom_range(4095, 1)));
    run_phase(80);

    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    sb.finish();

    $display("Covered %0d input transfers and %0d result transfers over %0d clock rate settings,",
             sent, received, rate_writes + 1);
    $display("including count clears, zero and wrapped periods, all directions and output stalls.");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
